### hdl/rmj_pkg.sv
`timescale 1ns / 1ps
package rmj_pkg;
	localparam int MAG_W = 32;
	localparam int WIDE_W = 64;
	localparam int ROOT_W = 32;
	localparam int ROOT_REM_W = 34;
	localparam int THR_W = 16;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	// Register index as seen on paddr[2].
	localparam logic REG_SINGULAR_THRESHOLD = 1'b0;

	typedef struct packed {
		logic npx;
		logic npy;
		logic nc4;
		logic sing;
		logic wovf;
	} side_t;

	typedef struct packed {
		logic [WIDE_W-1:0] rad;
		logic [ROOT_W-1:0] root;
		logic [ROOT_REM_W-1:0] rem;
		logic [MAG_W-1:0] pxm;
		logic [MAG_W-1:0] pym;
	} root_t;

	typedef struct packed {
		logic [DATA_W-1:0] drange_dpx;
		logic [DATA_W-1:0] drange_dpy;
		logic [DATA_W-1:0] dbearing_dpx;
		logic [DATA_W-1:0] dbearing_dpy;
		logic [DATA_W-1:0] drate_dpx;
		logic [DATA_W-1:0] drate_dpy;
		logic singular;
	} res_t;
endpackage

### hdl/rmj_div.sv
`timescale 1ns / 1ps
module rmj_div #(
	parameter int DW = 32,
	parameter int QW = 17
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] rem_in,
	input  logic [QW-1:0] tail_in,
	input  logic [DW-1:0] den_in,
	output logic [QW-1:0] quo
);
	logic [DW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] tail_s [QW];
	logic [QW-1:0] quo_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DW-1:0] rem_p;
		logic [DW-1:0] den_p;
		logic [QW-1:0] tail_p;
		logic [QW-1:0] quo_p;
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic take;
		if (i == 0) begin : g_first
			assign rem_p = rem_in;
			assign den_p = den_in;
			assign tail_p = tail_in;
			assign quo_p = '0;
		end else begin : g_next
			assign rem_p = rem_s[i-1];
			assign den_p = den_s[i-1];
			assign tail_p = tail_s[i-1];
			assign quo_p = quo_s[i-1];
		end
		assign trial = {rem_p, tail_p[QW-1]};
		assign diff = trial - {1'b0, den_p};
		assign take = trial >= {1'b0, den_p};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= take ? diff[DW-1:0] : trial[DW-1:0];
				den_s[i] <= den_p;
				tail_s[i] <= {tail_p[QW-2:0], 1'b0};
				quo_s[i] <= {quo_p[QW-2:0], take};
			end
		end
	end

	assign quo = quo_s[QW-1];
endmodule

### hdl/radar_measurement_jacobian.sv
`timescale 1ns / 1ps
// Radar measurement Jacobian for a constant-velocity state in signed fixed point.
// Input channel: pos_x, pos_y, vel_x, vel_y with in_valid and in_stall. A transfer
// happens on a rising edge with in_valid high and in_stall low.
// Output channel: the six Jacobian entries and the singular flag with out_valid and
// out_stall, transferred the same way.
// The threshold register is written through the APB port at byte address 0.
// One item is taken in every cycle while the output is not stalled; the pipeline depth
// is set by the square root, which resolves one root bit per stage, followed by the
// quotient dividers, which resolve one quotient bit per stage.
// Reset empties the pipeline and sets the threshold to 7.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_stall rises in the same cycle; no item is lost or repeated.
module radar_measurement_jacobian #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [31:0]          pos_x,
	input  logic signed [31:0]          pos_y,
	input  logic signed [31:0]          vel_x,
	input  logic signed [31:0]          vel_y,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [31:0]          drange_dpx,
	output logic signed [31:0]          drange_dpy,
	output logic signed [31:0]          dbearing_dpx,
	output logic signed [31:0]          dbearing_dpy,
	output logic signed [31:0]          drate_dpx,
	output logic signed [31:0]          drate_dpy,
	output logic                        singular,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rmj_pkg::ADDR_W-1:0]  paddr,
	input  logic [rmj_pkg::DATA_W-1:0]  pwdata,
	output logic [rmj_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	localparam int F = FRAC_BITS;
	localparam int SQ_IN = 2;
	localparam int ROOT_END = SQ_IN + rmj_pkg::ROOT_W;
	localparam int RW = F + 1;
	localparam int R_END = ROOT_END + RW;
	localparam int BQW = 2 * F + 1;
	localparam int BEAR_END = SQ_IN + BQW;
	localparam int WQW = 32 + F;
	localparam int W_END = SQ_IN + WQW;
	localparam int M1 = R_END + 1;
	localparam int M2 = R_END + 2;
	localparam int OUT = R_END + 3;
	localparam int WL = WQW / 2;
	localparam int WH = WQW - WL;
	localparam int PW = RW + WQW;
	localparam logic [WQW-1:0] W_CAP = {2'b01, {(WQW - 2){1'b0}}};
	localparam logic [PW-1:0] RATE_LIM = PW'(64'h8000_0000);

	function automatic logic [31:0] sat_sign(input logic neg, input logic [63:0] mag);
		logic [63:0] lim;
		logic [63:0] m;
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		m = (mag > lim) ? lim : mag;
		return neg ? (32'd0 - m[31:0]) : m[31:0];
	endfunction

	logic adv;
	logic [rmj_pkg::THR_W-1:0] thr_q;
	logic v_s [1:OUT];

	logic [31:0] pxm_s1, pym_s1;
	logic npx_s1, npy_s1, s1n_s1, s2n_s1;
	logic [63:0] pxx_s1, pyy_s1, p1_s1, p2_s1;

	logic [63:0] c1_s2, c4_s2;
	logic [31:0] pxm_s2, pym_s2;

	rmj_pkg::side_t side_s [2:M2];
	rmj_pkg::root_t root_s [SQ_IN+1:ROOT_END];

	logic [WQW-1:0] wq;
	logic [BQW-1:0] bqx, bqy;
	logic [RW-1:0] rqx, rqy;
	logic [WQW-1:0] w_s;
	logic [BQW-1:0] bxd_s [BEAR_END+1:M2];
	logic [BQW-1:0] byd_s [BEAR_END+1:M2];
	logic [RW-1:0] rxd_s [M1:M2];
	logic [RW-1:0] ryd_s [M1:M2];
	logic [RW+WL-1:0] ppx_lo_m1, ppy_lo_m1;
	logic [RW+WH-1:0] ppx_hi_m1, ppy_hi_m1;
	logic [31:0] ratex_m2, ratey_m2;
	rmj_pkg::res_t res_s;

	assign adv = !(v_s[OUT] && out_stall);
	assign in_stall = !adv;
	assign out_valid = v_s[OUT];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= rmj_pkg::THR_W'(7);
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == rmj_pkg::REG_SINGULAR_THRESHOLD) begin
			thr_q <= pwdata[rmj_pkg::THR_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == rmj_pkg::REG_SINGULAR_THRESHOLD) begin
			prdata = rmj_pkg::DATA_W'(thr_q);
		end else begin
			prdata = '0;
		end
	end

	for (genvar k = 1; k <= OUT; k++) begin : g_valid
		if (k == 1) begin : g_head
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (adv) begin
					v_s[k] <= in_valid;
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (adv) begin
					v_s[k] <= v_s[k-1];
				end
			end
		end
	end

	// Stage 1: magnitudes and the four products.
	always_ff @(posedge clk) begin
		logic [31:0] ax, ay, bx, by;
		ax = pos_x[31] ? 32'(~pos_x + 32'sd1) : 32'(pos_x);
		ay = pos_y[31] ? 32'(~pos_y + 32'sd1) : 32'(pos_y);
		bx = vel_x[31] ? 32'(~vel_x + 32'sd1) : 32'(vel_x);
		by = vel_y[31] ? 32'(~vel_y + 32'sd1) : 32'(vel_y);
		if (adv) begin
			pxm_s1 <= ax;
			pym_s1 <= ay;
			npx_s1 <= pos_x[31];
			npy_s1 <= pos_y[31];
			s1n_s1 <= vel_x[31] != pos_y[31];
			s2n_s1 <= vel_y[31] != pos_x[31];
			pxx_s1 <= 64'(ax) * 64'(ax);
			pyy_s1 <= 64'(ay) * 64'(ay);
			p1_s1 <= 64'(bx) * 64'(ay);
			p2_s1 <= 64'(by) * 64'(ax);
		end
	end

	// Stage 2: squared range, cross term and the singular test.
	always_ff @(posedge clk) begin
		logic [63:0] c1, c4;
		logic nc4;
		c1 = pxx_s1 + pyy_s1;
		if (s1n_s1 != s2n_s1) begin
			c4 = p1_s1 + p2_s1;
			nc4 = s1n_s1;
		end else if (p1_s1 >= p2_s1) begin
			c4 = p1_s1 - p2_s1;
			nc4 = s1n_s1;
		end else begin
			c4 = p2_s1 - p1_s1;
			nc4 = !s2n_s1;
		end
		if (adv) begin
			c1_s2 <= c1;
			c4_s2 <= c4;
			pxm_s2 <= pxm_s1;
			pym_s2 <= pym_s1;
			side_s[2] <= '{npx: npx_s1, npy: npy_s1, nc4: nc4,
				sing: (c1 == 64'd0) || (c1 < (64'(thr_q) << F)), wovf: 1'b0};
		end
	end

	for (genvar k = 3; k <= M2; k++) begin : g_side
		if (k == 3) begin : g_ovf
			always_ff @(posedge clk) begin
				if (adv) begin
					side_s[k] <= '{npx: side_s[k-1].npx, npy: side_s[k-1].npy,
						nc4: side_s[k-1].nc4, sing: side_s[k-1].sing,
						wovf: 64'(c4_s2[63:32]) >= c1_s2};
				end
			end
		end else begin : g_copy
			always_ff @(posedge clk) begin
				if (adv) begin
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	// Square root, one result bit per stage.
	for (genvar i = 0; i < rmj_pkg::ROOT_W; i++) begin : g_root
		rmj_pkg::root_t prv;
		rmj_pkg::root_t nxt;
		logic [35:0] cur;
		logic [35:0] trial;
		logic take;
		if (i == 0) begin : g_first
			assign prv = '{rad: c1_s2, root: '0, rem: '0, pxm: pxm_s2, pym: pym_s2};
		end else begin : g_next
			assign prv = root_s[SQ_IN+i];
		end
		assign cur = {prv.rem, prv.rad[63:62]};
		assign trial = 36'({prv.root, 2'b01});
		assign take = cur >= trial;
		always_comb begin
			nxt = prv;
			nxt.rad = prv.rad << 2;
			nxt.root = {prv.root[rmj_pkg::ROOT_W-2:0], take};
			nxt.rem = take ? 34'(cur - trial) : cur[rmj_pkg::ROOT_REM_W-1:0];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				root_s[SQ_IN+1+i] <= nxt;
			end
		end
	end

	rmj_div #(.DW(64), .QW(WQW)) u_wdiv (
		.clk(clk), .en(adv),
		.rem_in(64'(c4_s2[63:32])),
		.tail_in({c4_s2[31:0], {F{1'b0}}}),
		.den_in(c1_s2),
		.quo(wq)
	);

	rmj_div #(.DW(64), .QW(BQW)) u_bxdiv (
		.clk(clk), .en(adv),
		.rem_in(64'(pxm_s2[31:1])),
		.tail_in({pxm_s2[0], {(2 * F){1'b0}}}),
		.den_in(c1_s2),
		.quo(bqx)
	);

	rmj_div #(.DW(64), .QW(BQW)) u_bydiv (
		.clk(clk), .en(adv),
		.rem_in(64'(pym_s2[31:1])),
		.tail_in({pym_s2[0], {(2 * F){1'b0}}}),
		.den_in(c1_s2),
		.quo(bqy)
	);

	rmj_div #(.DW(32), .QW(RW)) u_rxdiv (
		.clk(clk), .en(adv),
		.rem_in({1'b0, root_s[ROOT_END].pxm[31:1]}),
		.tail_in({root_s[ROOT_END].pxm[0], {F{1'b0}}}),
		.den_in(root_s[ROOT_END].root),
		.quo(rqx)
	);

	rmj_div #(.DW(32), .QW(RW)) u_rydiv (
		.clk(clk), .en(adv),
		.rem_in({1'b0, root_s[ROOT_END].pym[31:1]}),
		.tail_in({root_s[ROOT_END].pym[0], {F{1'b0}}}),
		.den_in(root_s[ROOT_END].root),
		.quo(rqy)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_s[W_END].wovf || wq > W_CAP) begin
				w_s <= W_CAP;
			end else begin
				w_s <= wq;
			end
		end
	end

	for (genvar k = BEAR_END + 1; k <= M2; k++) begin : g_bear
		if (k == BEAR_END + 1) begin : g_head
			always_ff @(posedge clk) begin
				if (adv) begin
					bxd_s[k] <= bqx;
					byd_s[k] <= bqy;
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk) begin
				if (adv) begin
					bxd_s[k] <= bxd_s[k-1];
					byd_s[k] <= byd_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rxd_s[M1] <= rqx;
			ryd_s[M1] <= rqy;
			rxd_s[M2] <= rxd_s[M1];
			ryd_s[M2] <= ryd_s[M1];
			ppx_lo_m1 <= (RW+WL)'(rqx) * (RW+WL)'(w_s[WL-1:0]);
			ppy_lo_m1 <= (RW+WL)'(rqy) * (RW+WL)'(w_s[WL-1:0]);
			ppx_hi_m1 <= (RW+WH)'(rqx) * (RW+WH)'(w_s[WQW-1:WL]);
			ppy_hi_m1 <= (RW+WH)'(rqy) * (RW+WH)'(w_s[WQW-1:WL]);
		end
	end

	always_ff @(posedge clk) begin
		logic [PW-1:0] sx, sy;
		sx = ((PW'(ppx_hi_m1) << WL) + PW'(ppx_lo_m1)) >> F;
		sy = ((PW'(ppy_hi_m1) << WL) + PW'(ppy_lo_m1)) >> F;
		if (adv) begin
			ratex_m2 <= (sx > RATE_LIM) ? 32'h8000_0000 : sx[31:0];
			ratey_m2 <= (sy > RATE_LIM) ? 32'h8000_0000 : sy[31:0];
		end
	end

	always_ff @(posedge clk) begin
		rmj_pkg::side_t sd;
		sd = side_s[M2];
		if (adv) begin
			if (sd.sing) begin
				res_s <= '{singular: 1'b1, default: '0};
			end else begin
				res_s.drange_dpx <= sat_sign(sd.npx, 64'(rxd_s[M2]));
				res_s.drange_dpy <= sat_sign(sd.npy, 64'(ryd_s[M2]));
				res_s.dbearing_dpx <= sat_sign(!sd.npy, 64'(byd_s[M2]));
				res_s.dbearing_dpy <= sat_sign(sd.npx, 64'(bxd_s[M2]));
				res_s.drate_dpx <= sat_sign(sd.npy != sd.nc4, 64'(ratey_m2));
				res_s.drate_dpy <= sat_sign(!(sd.npx != sd.nc4), 64'(ratex_m2));
				res_s.singular <= 1'b0;
			end
		end
	end

	assign drange_dpx = res_s.drange_dpx;
	assign drange_dpy = res_s.drange_dpy;
	assign dbearing_dpx = res_s.dbearing_dpx;
	assign dbearing_dpy = res_s.dbearing_dpy;
	assign drate_dpx = res_s.drate_dpx;
	assign drate_dpy = res_s.drate_dpy;
	assign singular = res_s.singular;
endmodule

### hdl/rmj_check.sv
`timescale 1ns / 1ps
module rmj_check (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [31:0]                drange_dpx,
	input logic [31:0]                drange_dpy,
	input logic [31:0]                dbearing_dpx,
	input logic [31:0]                dbearing_dpy,
	input logic [31:0]                drate_dpx,
	input logic [31:0]                drate_dpy,
	input logic                       singular,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [rmj_pkg::ADDR_W-1:0] paddr,
	input logic [rmj_pkg::DATA_W-1:0] pwdata,
	input logic [rmj_pkg::DATA_W-1:0] prdata,
	input logic                       pready
);
	// A stalled result stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(drange_dpx) && $stable(drange_dpy)
			&& $stable(dbearing_dpx) && $stable(dbearing_dpy) && $stable(drate_dpx)
			&& $stable(drate_dpy) && $stable(singular))
		else $error("stalled result changed");

	// The input side only stalls when a finished result is held back.
	a_install: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> drange_dpx == 32'd0 && drange_dpy == 32'd0
			&& dbearing_dpx == 32'd0 && dbearing_dpy == 32'd0
			&& drate_dpx == 32'd0 && drate_dpy == 32'd0)
		else $error("singular result with nonzero entries");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready
			&& paddr[2] == rmj_pkg::REG_SINGULAR_THRESHOLD
			##1 paddr[2] == rmj_pkg::REG_SINGULAR_THRESHOLD
			|-> prdata == {16'd0, $past(pwdata[15:0])})
		else $error("threshold readback mismatch");
endmodule

bind radar_measurement_jacobian rmj_check u_rmj_check (.*);
